### hdl/brf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the byte ring FIFO: store geometry, field
// widths, request codes, the command that travels from front to back, and
// the result record.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  localparam int DATA_W      = 8;
  localparam int CNT_W       = 7;
  localparam int LVL_W       = 9;
  localparam int REQ_W       = 3;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(64);
  localparam logic [LVL_W-1:0] CAP_MAX   = LVL_W'(STORE_DEPTH);

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);

  // Request codes as they arrive on the input channel.
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUT      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DROP_OLD = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DROP_NEW = 3'd4;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_PUT,
    OP_READ,
    OP_DROP_OLD,
    OP_DROP_NEW,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  count;
    logic              strict;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              data_valid;
    logic              last;
    logic [CNT_W-1:0]  done_count;
    logic [LVL_W-1:0]  fill_level;
    logic [LVL_W-1:0]  free_space;
  } res_t;

endpackage

### hdl/brf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds while no read is enabled.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/brf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_front
// Accepts requests, decodes the request type, saturates the count and
// holds the resulting commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module brf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [brf_pkg::REQ_W-1:0]  in_req_type,
  input  logic [brf_pkg::DATA_W-1:0] in_data_byte,
  input  logic [brf_pkg::CNT_W-1:0]  in_count,
  input  logic                       in_strict,
  output logic                       cmd_valid,
  output brf_pkg::cmd_t              cmd,
  input  logic                       cmd_take
);

  brf_pkg::cmd_t               q_r [brf_pkg::QUEUE_DEPTH];
  brf_pkg::cmd_t               new_cmd;
  logic [brf_pkg::QIDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [brf_pkg::QIDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [brf_pkg::QIDX_W:0]    fill_r, fill_nxt;
  logic                        accept;

  // Decode the request and clamp the count.
  always_comb begin
    unique case (in_req_type)
      brf_pkg::REQ_CLEAR:    new_cmd.op = brf_pkg::OP_CLEAR;
      brf_pkg::REQ_PUT:      new_cmd.op = brf_pkg::OP_PUT;
      brf_pkg::REQ_READ:     new_cmd.op = brf_pkg::OP_READ;
      brf_pkg::REQ_DROP_OLD: new_cmd.op = brf_pkg::OP_DROP_OLD;
      brf_pkg::REQ_DROP_NEW: new_cmd.op = brf_pkg::OP_DROP_NEW;
      default:               new_cmd.op = brf_pkg::OP_NOP;
    endcase
    new_cmd.data   = in_data_byte;
    new_cmd.count  = (in_count > brf_pkg::MAX_COUNT) ? brf_pkg::MAX_COUNT : in_count;
    new_cmd.strict = in_strict;
  end

  assign in_stall  = (fill_r == (brf_pkg::QIDX_W + 1)'(brf_pkg::QUEUE_DEPTH));
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_r[rd_idx_r];

  always_comb begin
    wr_idx_nxt = accept ? wr_idx_r + brf_pkg::QIDX_W'(1) : wr_idx_r;
    rd_idx_nxt = cmd_take ? rd_idx_r + brf_pkg::QIDX_W'(1) : rd_idx_r;
    fill_nxt   = fill_r;
    if (accept && !cmd_take) begin
      fill_nxt = fill_r + (brf_pkg::QIDX_W + 1)'(1);
    end else if (!accept && cmd_take) begin
      fill_nxt = fill_r - (brf_pkg::QIDX_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_idx_r] <= new_cmd;
    end
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

### hdl/brf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brf_back
// Executes queued commands against the circular store: keeps the pointers
// and the occupancy, moves one byte per cycle for puts and, while the result
// channel does not stall, for reads, and drives the registered result channel.
// ----------------------------------------------------------------------------
module brf_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [brf_pkg::LVL_W-1:0] cap,
  input  logic                      cfg_clear,
  input  logic                      cmd_valid,
  input  brf_pkg::cmd_t             cmd,
  output logic                      cmd_take,
  output logic                      res_valid,
  output brf_pkg::res_t             res,
  input  logic                      res_stall
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_EMIT
  } state_t;

  localparam int PTR_W = brf_pkg::PTR_W;
  localparam int LVL_W = brf_pkg::LVL_W;
  localparam int CNT_W = brf_pkg::CNT_W;

  state_t                      state_r, state_nxt;
  logic [PTR_W-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0]            occ_r, occ_nxt;
  logic [CNT_W-1:0]            rem_r, rem_nxt;
  logic [CNT_W-1:0]            done_r, done_nxt;
  logic [brf_pkg::DATA_W-1:0]  put_byte_r, put_byte_nxt;
  logic                        pend_r, pend_nxt;
  brf_pkg::res_t               pend_meta_r, pend_meta_nxt;
  logic                        out_valid_r, out_valid_nxt;
  brf_pkg::res_t               out_res_r, out_res_nxt;

  logic [LVL_W-1:0]            free;
  logic [LVL_W-1:0]            cnt_ext;
  logic [CNT_W-1:0]            clamp_occ;
  logic [CNT_W-1:0]            put_n;
  logic [CNT_W-1:0]            read_n;
  logic [PTR_W-1:0]            rd_inc, wr_inc;
  logic [LVL_W-1:0]            old_sum, new_sum;
  logic [PTR_W-1:0]            drop_old_ptr, drop_new_ptr;
  logic                        out_free, load_pend, start, issue;
  logic                        ram_we, ram_re;
  logic [brf_pkg::DATA_W-1:0]  ram_rdata;
  logic [LVL_W-1:0]            occ_dec;

  brf_ram #(
    .WIDTH (brf_pkg::DATA_W),
    .DEPTH (brf_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (put_byte_r),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // Sizes of the current head command against the present fill state.
  always_comb begin
    free      = cap - occ_r;
    cnt_ext   = {2'b00, cmd.count};
    clamp_occ = (cnt_ext < occ_r) ? cmd.count : occ_r[CNT_W-1:0];
    if (cmd.strict && (free < cnt_ext)) begin
      put_n = '0;
    end else begin
      put_n = (cnt_ext < free) ? cmd.count : free[CNT_W-1:0];
    end
    if (cmd.strict && (occ_r < cnt_ext)) begin
      read_n = '0;
    end else begin
      read_n = clamp_occ;
    end
  end

  // Pointer arithmetic, wrapping at the effective capacity.
  always_comb begin
    rd_inc  = (({1'b0, rd_ptr_r} + LVL_W'(1)) == cap) ? '0 : rd_ptr_r + PTR_W'(1);
    wr_inc  = (({1'b0, wr_ptr_r} + LVL_W'(1)) == cap) ? '0 : wr_ptr_r + PTR_W'(1);
    old_sum = {1'b0, rd_ptr_r} + {2'b00, clamp_occ};
    if (old_sum >= cap) begin
      old_sum = old_sum - cap;
    end
    drop_old_ptr = old_sum[PTR_W-1:0];
    if ({1'b0, wr_ptr_r} < {2'b00, clamp_occ}) begin
      new_sum = {1'b0, wr_ptr_r} + cap - {2'b00, clamp_occ};
    end else begin
      new_sum = {1'b0, wr_ptr_r} - {2'b00, clamp_occ};
    end
    drop_new_ptr = new_sum[PTR_W-1:0];
  end

  assign out_free  = !out_valid_r || !res_stall;
  assign load_pend = pend_r && out_free;
  assign start     = (state_r == ST_IDLE) && !pend_r && cmd_valid;
  assign issue     = (state_r == ST_READ) && (!pend_r || load_pend);
  assign cmd_take  = start;
  assign ram_we    = (state_r == ST_PUT);
  assign ram_re    = issue;
  assign occ_dec   = occ_r - LVL_W'(1);
  assign res_valid = out_valid_r;
  assign res       = out_res_r;

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    occ_nxt       = occ_r;
    rem_nxt       = rem_r;
    done_nxt      = done_r;
    put_byte_nxt  = put_byte_r;
    pend_meta_nxt = pend_meta_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          done_nxt  = '0;
          state_nxt = ST_EMIT;
          case (cmd.op)
            brf_pkg::OP_CLEAR: begin
              wr_ptr_nxt = '0;
              rd_ptr_nxt = '0;
              occ_nxt    = '0;
            end
            brf_pkg::OP_PUT: begin
              put_byte_nxt = cmd.data;
              rem_nxt      = put_n;
              if (put_n != '0) begin
                state_nxt = ST_PUT;
              end
            end
            brf_pkg::OP_READ: begin
              rem_nxt = read_n;
              if (read_n != '0) begin
                state_nxt = ST_READ;
              end
            end
            brf_pkg::OP_DROP_OLD: begin
              rd_ptr_nxt = drop_old_ptr;
              occ_nxt    = occ_r - {2'b00, clamp_occ};
              done_nxt   = clamp_occ;
            end
            brf_pkg::OP_DROP_NEW: begin
              wr_ptr_nxt = drop_new_ptr;
              occ_nxt    = occ_r - {2'b00, clamp_occ};
              done_nxt   = clamp_occ;
            end
            default: begin
              done_nxt = '0;
            end
          endcase
        end
      end
      ST_PUT: begin
        wr_ptr_nxt = wr_inc;
        occ_nxt    = occ_r + LVL_W'(1);
        done_nxt   = done_r + CNT_W'(1);
        rem_nxt    = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_READ: begin
        if (issue) begin
          rd_ptr_nxt               = rd_inc;
          occ_nxt                  = occ_dec;
          done_nxt                 = done_r + CNT_W'(1);
          rem_nxt                  = rem_r - CNT_W'(1);
          pend_meta_nxt.data_out   = '0;
          pend_meta_nxt.data_valid = 1'b1;
          pend_meta_nxt.last       = (rem_r == CNT_W'(1));
          pend_meta_nxt.done_count = done_r + CNT_W'(1);
          pend_meta_nxt.fill_level = occ_dec;
          pend_meta_nxt.free_space = cap - occ_dec;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase

    // A capacity write restarts the FIFO empty.
    if (cfg_clear) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      occ_nxt    = '0;
    end
  end

  always_comb begin
    pend_nxt = issue ? 1'b1 : (load_pend ? 1'b0 : pend_r);
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && res_stall;
    if (load_pend) begin
      out_res_nxt          = pend_meta_r;
      out_res_nxt.data_out = ram_rdata;
      out_valid_nxt        = 1'b1;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_res_nxt.data_out   = '0;
      out_res_nxt.data_valid = 1'b0;
      out_res_nxt.last       = 1'b1;
      out_res_nxt.done_count = done_r;
      out_res_nxt.fill_level = occ_r;
      out_res_nxt.free_space = cap - occ_r;
      out_valid_nxt          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    done_r      <= done_nxt;
    put_byte_r  <= put_byte_nxt;
    pend_meta_r <= pend_meta_nxt;
    out_res_r   <= out_res_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      occ_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      occ_r       <= occ_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/byte_ring_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte FIFO in a 256-entry circular store with a programmable wrap point,
// driven by clear, put, read and drop requests.
// ----------------------------------------------------------------------------
// Each request on the input channel is decoded by a front end and placed in
// a two-entry command queue; a back end then carries it out against a
// single-port-write, single-port-read store. A put writes its byte once per
// cycle, for its count clamped to the free space, before its single result
// appears. A read pops one byte per cycle when the result channel does not
// stall, giving one result per byte, the last one marked; with the back end
// idle, the first byte passes from the accepted request through the command
// queue, the back end state register, the registered store read and the
// result register. Clear, both drops and an unknown request type finish
// with a single result. The store's one write port and one read port set
// the rate of one byte per cycle, for reads while the result channel does
// not stall. The capacity register (address 0) sets the wrap point; 0 acts
// as 1 and values above 256 act as 256. Writing it empties the FIFO but
// keeps the stored bytes, and it must only be written while the block is
// idle. Every result carries the fill level and free space left after it,
// and a strict put or read either handles its whole count or does nothing.
// ----------------------------------------------------------------------------
module byte_ring_fifo (
  input  logic                       clk,
  input  logic                       rst_n,

  // Request channel.
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [brf_pkg::REQ_W-1:0]  in_req_type,
  input  logic [brf_pkg::DATA_W-1:0] in_data_byte,
  input  logic [brf_pkg::CNT_W-1:0]  in_count,
  input  logic                       in_strict,

  // Result channel.
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brf_pkg::DATA_W-1:0] out_data_out,
  output logic                       out_data_valid,
  output logic                       out_last,
  output logic [brf_pkg::CNT_W-1:0]  out_done_count,
  output logic [brf_pkg::LVL_W-1:0]  out_fill_level,
  output logic [brf_pkg::LVL_W-1:0]  out_free_space,

  // Configuration port.
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int LVL_W = brf_pkg::LVL_W;

  logic [LVL_W-1:0] capacity_r, capacity_nxt;
  logic [LVL_W-1:0] cap_eff;
  logic             cfg_write;
  logic             cfg_clear;
  logic             cmd_valid;
  logic             cmd_take;
  brf_pkg::cmd_t    cmd;
  logic             res_valid;
  brf_pkg::res_t    res;

  // The port never waits. Only one register exists; addresses with bit 2
  // set lie beyond it, so writes there are ignored and reads return zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_clear = cfg_write && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? {23'd0, capacity_r} : 32'd0;

  assign capacity_nxt = cfg_clear ? pwdata[LVL_W-1:0] : capacity_r;

  // Effective capacity: zero behaves as one, anything above the store
  // depth behaves as the full store.
  always_comb begin
    if (capacity_r == '0) begin
      cap_eff = LVL_W'(1);
    end else if (capacity_r > brf_pkg::CAP_MAX) begin
      cap_eff = brf_pkg::CAP_MAX;
    end else begin
      cap_eff = capacity_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= brf_pkg::CAP_MAX;
    end else begin
      capacity_r <= capacity_nxt;
    end
  end

  // Front end: takes requests and queues decoded commands.
  brf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .in_count     (in_count),
    .in_strict    (in_strict),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // Back end: owns the store, the pointers and the result register.
  brf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (cap_eff),
    .cfg_clear (cfg_clear),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (res),
    .res_stall (out_stall)
  );

  assign out_valid      = res_valid;
  assign out_data_out   = res.data_out;
  assign out_data_valid = res.data_valid;
  assign out_last       = res.last;
  assign out_done_count = res.done_count;
  assign out_fill_level = res.fill_level;
  assign out_free_space = res.free_space;

`ifndef NO_ASSERTIONS
  // Fill level and free space always add up to the effective capacity.
  a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, out_fill_level} + {1'b0, out_free_space}) == {1'b0, cap_eff}))
    else $error("fill level and free space do not add up to capacity");

  // A result without a popped byte is a single, final, zero-data result.
  a_status_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data_valid) |-> (out_last && (out_data_out == '0)))
    else $error("status result is not final or carries data");

  // Every popped byte counts itself in the running total.
  a_pop_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_valid) |-> (out_done_count != '0))
    else $error("popped byte reported with zero done count");
`endif

endmodule
